[design/ftvp_pkg.sv]
// ----------------------------------------------------------------------------
// ftvp_pkg
// Types and codes shared by the FEC TLV value parser modules.
// ----------------------------------------------------------------------------
package ftvp_pkg;

   typedef enum logic [2:0] {
      PH_TYPE  = 3'd0,
      PH_FAMHI = 3'd1,
      PH_FAMLO = 3'd2,
      PH_LEN   = 3'd3,
      PH_ADDR  = 3'd4
   } phase_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
   localparam logic [2:0] ST_BAD_FAM   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_BAD_HOST  = 3'd4;
   localparam logic [2:0] ST_TRUNC     = 3'd5;

   localparam logic [2:0] EL_NONE      = 3'd0;
   localparam logic [2:0] EL_WILDCARD  = 3'd1;
   localparam logic [2:0] EL_PREFIX    = 3'd2;
   localparam logic [2:0] EL_HOST      = 3'd3;
   localparam logic [2:0] EL_CRLSP     = 3'd4;

   localparam logic [15:0] FAM_IPV4    = 16'd1;
   localparam logic [7:0]  MAX_PREFIX  = 8'd32;
   localparam logic [7:0]  HOST_LEN    = 8'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  element_type;
      logic [15:0] address_family;
      logic [5:0]  prefix_length;
      logic [31:0] address_value;
      logic        end_of_value;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } result_type;

endpackage

[design/ftvp_in_stage.sv]
// ----------------------------------------------------------------------------
// ftvp_in_stage
// Input register: holds one byte until the parser can step on it.
// ----------------------------------------------------------------------------
module ftvp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ftvp_pkg::req_item_type req_data,
   input  logic                  advance,
   output ftvp_pkg::stage_type   stage
);
   import ftvp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // an empty register fills even while the parser is held
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[design/ftvp_parser.sv]
// ----------------------------------------------------------------------------
// ftvp_parser
// Element state machine: one byte per step, at most one result per byte.
// ----------------------------------------------------------------------------
module ftvp_parser (
   input  logic                clock,
   input  logic                reset,
   input  ftvp_pkg::stage_type stage,
   input  logic                advance,
   output ftvp_pkg::result_type result
);
   import ftvp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  type_ff, type_in;
   logic [15:0] fam_ff, fam_in;
   logic [5:0]  plen_ff, plen_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] addr_ff, addr_in;
   logic        disc_ff, disc_in;

   logic        step;
   logic [7:0]  b;
   logic        fin;
   logic        do_ok, do_err;
   logic [2:0]  err_code;
   logic [2:0]  ok_type;
   logic [15:0] ok_fam;
   logic [5:0]  ok_plen;
   logic [31:0] ok_addr;
   logic [6:0]  len_sum;
   logic [2:0]  len_left;
   logic [6:0]  tot_sum;
   logic [2:0]  total;
   logic [2:0]  idx_full;
   logic [31:0] placed;
   logic [31:0] acc;
   logic [2:0]  left_dec;

   assign step = stage.valid && advance;
   assign b    = stage.item.data_byte;
   assign fin  = stage.item.final_byte;

   always_comb begin
      len_sum  = {1'b0, b[5:0]} + 7'd7;
      len_left = len_sum[5:3];
      tot_sum  = {1'b0, plen_ff} + 7'd7;
      total    = tot_sum[5:3];
      idx_full = total - left_ff;
      case (idx_full[1:0])
         2'd0:    placed = {b, 24'h0};
         2'd1:    placed = {8'h0, b, 16'h0};
         2'd2:    placed = {16'h0, b, 8'h0};
         default: placed = {24'h0, b};
      endcase
      acc      = addr_ff | placed;
      left_dec = left_ff - 3'd1;
   end

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      fam_in   = fam_ff;
      plen_in  = plen_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      disc_in  = disc_ff;
      do_ok    = 1'b0;
      do_err   = 1'b0;
      err_code = ST_OK;
      ok_type  = EL_NONE;
      ok_fam   = 16'h0;
      ok_plen  = 6'h0;
      ok_addr  = 32'h0;

      if (disc_ff) begin
         if (fin) begin
            disc_in  = 1'b0;
            phase_in = PH_TYPE;
         end
      end else begin
         case (phase_ff)
            PH_TYPE: begin
               if (b == 8'(EL_WILDCARD) || b == 8'(EL_CRLSP)) begin
                  do_ok   = 1'b1;
                  ok_type = b[2:0];
               end else if (b == 8'(EL_PREFIX) || b == 8'(EL_HOST)) begin
                  if (fin) begin
                     do_err   = 1'b1;
                     err_code = ST_TRUNC;
                  end else begin
                     type_in  = b[2:0];
                     phase_in = PH_FAMHI;
                  end
               end else begin
                  do_err   = 1'b1;
                  err_code = ST_BAD_TYPE;
               end
            end
            PH_FAMHI: begin
               if (fin) begin
                  do_err   = 1'b1;
                  err_code = ST_TRUNC;
               end else begin
                  fam_in   = {b, 8'h0};
                  phase_in = PH_FAMLO;
               end
            end
            PH_FAMLO: begin
               if (fin) begin
                  do_err   = 1'b1;
                  err_code = ST_TRUNC;
               end else begin
                  fam_in   = {fam_ff[15:8], b};
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (fam_ff != FAM_IPV4) begin
                  do_err   = 1'b1;
                  err_code = ST_BAD_FAM;
               end else if (type_ff == EL_PREFIX && b > MAX_PREFIX) begin
                  do_err   = 1'b1;
                  err_code = ST_TOO_LONG;
               end else if (type_ff != EL_PREFIX && b != HOST_LEN) begin
                  do_err   = 1'b1;
                  err_code = ST_BAD_HOST;
               end else if (type_ff == EL_PREFIX && len_left == 3'd0) begin
                  // zero-length prefix completes here
                  do_ok   = 1'b1;
                  ok_type = type_ff;
                  ok_fam  = fam_ff;
                  ok_plen = b[5:0];
               end else if (fin) begin
                  do_err   = 1'b1;
                  err_code = ST_TRUNC;
               end else begin
                  addr_in  = 32'h0;
                  phase_in = PH_ADDR;
                  if (type_ff == EL_PREFIX) begin
                     plen_in = b[5:0];
                     left_in = len_left;
                  end else begin
                     plen_in = 6'(MAX_PREFIX);
                     left_in = 3'(HOST_LEN);
                  end
               end
            end
            PH_ADDR: begin
               if (left_dec == 3'd0) begin
                  do_ok   = 1'b1;
                  ok_type = type_ff;
                  ok_fam  = fam_ff;
                  ok_plen = plen_ff;
                  ok_addr = acc;
               end else if (fin) begin
                  do_err   = 1'b1;
                  err_code = ST_TRUNC;
               end else begin
                  addr_in = acc;
                  left_in = left_dec;
               end
            end
            default: begin
               phase_in = PH_TYPE;
               type_in  = 3'h0;
               fam_in   = 16'h0;
               plen_in  = 6'h0;
               left_in  = 3'h0;
               addr_in  = 32'h0;
            end
         endcase
      end

      // any result, or the final byte of a discarded element, restarts the element
      if (do_ok || do_err || (disc_ff && fin)) begin
         phase_in = PH_TYPE;
         type_in  = 3'h0;
         fam_in   = 16'h0;
         plen_in  = 6'h0;
         left_in  = 3'h0;
         addr_in  = 32'h0;
      end
      if (do_err) begin
         disc_in = !fin;
      end

      result.emit = do_ok || do_err;
      if (do_err) begin
         result.item = '{status: err_code, element_type: EL_NONE,
                         address_family: 16'h0, prefix_length: 6'h0,
                         address_value: 32'h0, end_of_value: 1'b1};
      end else begin
         result.item = '{status: ST_OK, element_type: ok_type,
                         address_family: ok_fam, prefix_length: ok_plen,
                         address_value: ok_addr, end_of_value: fin};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= 3'h0;
         fam_ff   <= 16'h0;
         plen_ff  <= 6'h0;
         left_ff  <= 3'h0;
         addr_ff  <= 32'h0;
         disc_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         fam_ff   <= fam_in;
         plen_ff  <= plen_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

[design/ftvp_out_stage.sv]
// ----------------------------------------------------------------------------
// ftvp_out_stage
// Result register toward the response channel.
// ----------------------------------------------------------------------------
module ftvp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  ftvp_pkg::result_type  result,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ftvp_pkg::rsp_item_type rsp_data
);
   import ftvp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;
   logic         load;

   // free, or its transfer completes this cycle
   assign advance = !valid_ff || !rsp_stall;
   assign load    = advance && stage_valid && result.emit;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[design/fec_tlv_value_parser.sv]
// ----------------------------------------------------------------------------
// fec_tlv_value_parser
// Byte-serial decoder for the value field of an LDP FEC TLV.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data  (data_byte, final_byte)
//   rsp      out  rsp_valid/rsp_stall  rsp_data  (status ... end_of_value)
//
// One byte per cycle sustained while rsp_stall is low; a result is formed from
// its byte in the input register by the parser and held in the result register.
// The per-byte phase update is the single step between those registers.
// reset (synchronous) returns the parser to the type-byte phase, empty.
// A stalled result holds; if the input register is empty, one more byte is
// taken into it, then req_stall rises until the result transfers.
// ----------------------------------------------------------------------------
module fec_tlv_value_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ftvp_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ftvp_pkg::rsp_item_type rsp_data
);
   import ftvp_pkg::*;

   stage_type  stage;
   result_type result;
   logic       advance;

   ftvp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .stage     (stage)
   );

   ftvp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   ftvp_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage.valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
